// ===== rtl/core/mfld_pkg.sv =====
// ----------------------------------------------------------------------------
// mfld_pkg: shared types and constants of the line drawer
// command codes, job classes and the job record passed from front to back
// ----------------------------------------------------------------------------
package mfld_pkg;

  // defaults for the top-level parameters
  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;
  localparam int DEF_QUEUE_DEPTH  = 2;

  // field widths fixed by the interface
  localparam int CMD_W    = 3;
  localparam int COORD_W  = 8;
  localparam int RADDR_W  = 10;
  localparam int BYTE_W   = 8;
  // error term spans -(dx+dy) .. dx+dy with dx, dy below 2**COORD_W
  localparam int ERR_W    = COORD_W + 2;
  localparam int KIND_W   = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PIXEL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_INVERT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // job classes as seen by the back end
  localparam logic [KIND_W-1:0] KIND_NOP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DRAW   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FILL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVERT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [COORD_W-1:0]      x0;
    logic [COORD_W-1:0]      y0;
    logic [COORD_W-1:0]      x1;
    logic [COORD_W-1:0]      y1;
    logic [COORD_W-1:0]      dx;
    logic [COORD_W-1:0]      dy;
    logic                    x_dec;
    logic                    y_dec;
    logic signed [ERR_W-1:0] err;
    logic                    color;
    logic [RADDR_W-1:0]      read_addr;
  } job_t;

endpackage

// ===== rtl/core/mfld_ram.sv =====
// ----------------------------------------------------------------------------
// mfld_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module mfld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mfld_queue.sv =====
// ----------------------------------------------------------------------------
// mfld_queue: short job queue between front and back
// holds classified jobs so each side stalls on its own
// ----------------------------------------------------------------------------
module mfld_queue import mfld_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("job pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("job popped from an empty queue");
`endif

endmodule

// ===== rtl/core/mfld_front.sv =====
// ----------------------------------------------------------------------------
// mfld_front: command intake and classification
// clamps line endpoints, checks pixel and read bounds, prepares the line
// deltas, step directions and initial error term
// ----------------------------------------------------------------------------
module mfld_front import mfld_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [COORD_W-1:0] in_x_first,
  input  logic [COORD_W-1:0] in_y_first,
  input  logic [COORD_W-1:0] in_x_last,
  input  logic [COORD_W-1:0] in_y_last,
  input  logic               in_color,
  input  logic [RADDR_W-1:0] in_read_addr,
  input  logic               init_done,
  input  logic               q_full,
  output logic               q_push,
  output job_t               q_job
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam logic [COORD_W:0] W_LIM = (COORD_W+1)'(PANEL_WIDTH);
  localparam logic [COORD_W:0] H_LIM = (COORD_W+1)'(PANEL_HEIGHT);
  localparam logic [COORD_W-1:0] X_MAX = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(PANEL_HEIGHT - 1);

  logic [COORD_W-1:0]      xa, ya, xb, yb;
  logic [COORD_W-1:0]      dx, dy;
  logic                    x_fwd, y_fwd;
  logic signed [ERR_W-1:0] half_dx, half_dy, err_init;
  logic                    pix_on_panel;
  logic                    read_in_store;

  assign in_stall = q_full || !init_done;
  assign q_push   = in_valid && !in_stall;

  // endpoint clamp
  assign xa = ({1'b0, in_x_first} >= W_LIM) ? X_MAX : in_x_first;
  assign ya = ({1'b0, in_y_first} >= H_LIM) ? Y_MAX : in_y_first;
  assign xb = ({1'b0, in_x_last}  >= W_LIM) ? X_MAX : in_x_last;
  assign yb = ({1'b0, in_y_last}  >= H_LIM) ? Y_MAX : in_y_last;

  assign x_fwd = (xa < xb);
  assign y_fwd = (ya < yb);
  assign dx    = x_fwd ? xb - xa : xa - xb;
  assign dy    = y_fwd ? yb - ya : ya - yb;

  // initial error, halved toward zero
  assign half_dx  = $signed({3'b000, dx[COORD_W-1:1]});
  assign half_dy  = $signed({3'b000, dy[COORD_W-1:1]});
  assign err_init = (dx > dy) ? half_dx : -half_dy;

  assign pix_on_panel  = ({1'b0, in_x_first} < W_LIM) && ({1'b0, in_y_first} < H_LIM);
  assign read_in_store = (32'(in_read_addr) < STORE_BYTES);

  always_comb begin
    q_job           = '0;
    q_job.color     = in_color;
    q_job.read_addr = in_read_addr;
    unique case (in_cmd)
      CMD_PIXEL: begin
        // a single pixel is a line whose endpoints coincide
        q_job.kind = pix_on_panel ? KIND_DRAW : KIND_NOP;
        q_job.x0   = in_x_first;
        q_job.y0   = in_y_first;
        q_job.x1   = in_x_first;
        q_job.y1   = in_y_first;
      end
      CMD_LINE: begin
        q_job.kind  = KIND_DRAW;
        q_job.x0    = xa;
        q_job.y0    = ya;
        q_job.x1    = xb;
        q_job.y1    = yb;
        q_job.dx    = dx;
        q_job.dy    = dy;
        q_job.x_dec = !x_fwd;
        q_job.y_dec = !y_fwd;
        q_job.err   = err_init;
      end
      CMD_FILL:   q_job.kind = KIND_FILL;
      CMD_INVERT: q_job.kind = KIND_INVERT;
      CMD_READ:   q_job.kind = read_in_store ? KIND_READ : KIND_NOP;
      default:    q_job.kind = KIND_NOP;
    endcase
  end

endmodule

// ===== rtl/core/mfld_back.sv =====
// ----------------------------------------------------------------------------
// mfld_back: command execution over the pixel store
// read-modify-write per pixel, line stepping, store sweeps, byte reads and
// the result register
// ----------------------------------------------------------------------------
module mfld_back import mfld_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              q_head,
  output logic              q_pop,
  output logic              init_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_read_data,
  output logic              out_inverted_now
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [AW-1:0] ROW_BYTES = AW'(PANEL_WIDTH);
  localparam logic [COORD_W:0] W_LIM = (COORD_W+1)'(PANEL_WIDTH);
  localparam logic [COORD_W:0] H_LIM = (COORD_W+1)'(PANEL_HEIGHT);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SWEEP     = 3'd1;
  localparam logic [2:0] ST_PIX_RD    = 3'd2;
  localparam logic [2:0] ST_PIX_WR    = 3'd3;
  localparam logic [2:0] ST_BYTE_RD   = 3'd4;
  localparam logic [2:0] ST_BYTE_WAIT = 3'd5;
  localparam logic [2:0] ST_DONE      = 3'd6;

  logic [2:0]              state_r, state_nxt;
  job_t                    job_r, job_nxt;
  logic [COORD_W-1:0]      x_r, x_nxt;
  logic [COORD_W-1:0]      y_r, y_nxt;
  logic signed [ERR_W-1:0] err_r, err_nxt;
  logic [AW-1:0]           addr_r, addr_nxt;
  logic [AW-1:0]           sweep_addr_r, sweep_addr_nxt;
  logic [BYTE_W-1:0]       fill_byte_r, fill_byte_nxt;
  logic                    flag_r, flag_nxt;
  logic                    init_done_r, init_done_nxt;
  logic [BYTE_W-1:0]       res_data_r, res_data_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]       out_data_r, out_data_nxt;
  logic                    out_inv_r, out_inv_nxt;

  logic [AW-1:0]           pix_addr;
  logic [BYTE_W-1:0]       bit_mask;
  logic [BYTE_W-1:0]       ram_rdata, ram_wdata, pix_byte;
  logic [AW-1:0]           ram_raddr, ram_waddr;
  logic                    ram_we;
  logic signed [ERR_W-1:0] dx_s, dy_s;
  logic                    step_x, step_y, at_end, slot_free;

  // the store keeps pixels xor the invert mask, so toggling invert costs
  // nothing and a drawn pixel stores its colour as given
  assign pix_addr = AW'(x_r) + AW'(y_r[COORD_W-1:3]) * ROW_BYTES;
  assign bit_mask = BYTE_W'(1) << y_r[2:0];
  assign pix_byte = job_r.color ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

  assign ram_raddr = (state_r == ST_BYTE_RD) ? AW'(job_r.read_addr) : pix_addr;
  assign ram_we    = (state_r == ST_SWEEP) || (state_r == ST_PIX_WR);
  assign ram_waddr = (state_r == ST_SWEEP) ? sweep_addr_r : addr_r;
  assign ram_wdata = (state_r == ST_SWEEP) ? fill_byte_r : pix_byte;

  mfld_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // line step decisions
  assign dx_s   = $signed({2'b00, job_r.dx});
  assign dy_s   = $signed({2'b00, job_r.dy});
  assign step_x = (err_r > -dx_s);
  assign step_y = (err_r < dy_s);
  assign at_end = (x_r == job_r.x1) && (y_r == job_r.y1);

  assign slot_free = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt      = state_r;
    job_nxt        = job_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    err_nxt        = err_r;
    addr_nxt       = addr_r;
    sweep_addr_nxt = sweep_addr_r;
    fill_byte_nxt  = fill_byte_r;
    flag_nxt       = flag_r;
    init_done_nxt  = init_done_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_inv_nxt    = out_inv_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          job_nxt      = q_head;
          x_nxt        = q_head.x0;
          y_nxt        = q_head.y0;
          err_nxt      = q_head.err;
          res_data_nxt = BYTE_ZERO;
          unique case (q_head.kind)
            KIND_DRAW: state_nxt = ST_PIX_RD;
            KIND_FILL: begin
              sweep_addr_nxt = '0;
              fill_byte_nxt  = (q_head.color ^ flag_r) ? BYTE_ONES : BYTE_ZERO;
              state_nxt      = ST_SWEEP;
            end
            KIND_INVERT: begin
              flag_nxt  = !flag_r;
              state_nxt = ST_DONE;
            end
            KIND_READ: state_nxt = ST_BYTE_RD;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SWEEP: begin
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_addr_r == LAST_ADDR) begin
          sweep_addr_nxt = '0;
          if (init_done_r) begin
            state_nxt = ST_DONE;
          end else begin
            init_done_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_PIX_RD: begin
        addr_nxt  = pix_addr;
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        if (at_end) begin
          state_nxt = ST_DONE;
        end else begin
          err_nxt = err_r - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
          if (step_x) begin
            x_nxt = job_r.x_dec ? x_r - 1'b1 : x_r + 1'b1;
          end
          if (step_y) begin
            y_nxt = job_r.y_dec ? y_r - 1'b1 : y_r + 1'b1;
          end
          state_nxt = ST_PIX_RD;
        end
      end
      ST_BYTE_RD: state_nxt = ST_BYTE_WAIT;
      ST_BYTE_WAIT: begin
        res_data_nxt = ram_rdata ^ {BYTE_W{flag_r}};
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_data_r;
          out_inv_nxt   = flag_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      sweep_addr_r <= '0;
      fill_byte_r  <= BYTE_ZERO;
      flag_r       <= 1'b0;
      init_done_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      fill_byte_r  <= fill_byte_nxt;
      flag_r       <= flag_nxt;
      init_done_r  <= init_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    err_r      <= err_nxt;
    addr_r     <= addr_nxt;
    res_data_r <= res_data_nxt;
    out_data_r <= out_data_nxt;
    out_inv_r  <= out_inv_nxt;
  end

  assign init_done        = init_done_r;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_data_r;
  assign out_inverted_now = out_inv_r;

`ifndef NO_ASSERTIONS
  a_pixel_on_panel: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_PIX_WR) |-> (({1'b0, x_r} < W_LIM) && ({1'b0, y_r} < H_LIM)))
    else $error("pixel write off the panel");
  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the completion state");
`endif

endmodule

// ===== rtl/core/mono_framebuffer_line_drawer.sv =====
// ----------------------------------------------------------------------------
// mono_framebuffer_line_drawer: drawing engine over a page-organized
// monochrome pixel store
// ----------------------------------------------------------------------------
// Commands set or clear a pixel, draw a clamped Bresenham line, fill the
// store, toggle invert or read one store byte; every command returns exactly
// one result transaction carrying the byte read (zero unless a read) and the
// invert flag after the command. Each store byte holds eight vertical pixels
// of one column, at index x + (y / 8) * PANEL_WIDTH. After reset the block
// clears all PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) store bytes (1024 at the
// defaults), one byte a cycle, and holds in_stall high until done. Commands
// run one at a time in the back end, whose store, with one write port and
// one read port, sets the pace: a pixel or a line makes one store read and
// one store write per pixel and a fill writes one store byte a cycle. The
// front end classifies and queues up to QUEUE_DEPTH (two by default)
// commands ahead, so intake continues while a long line is drawn and while
// a finished result waits in the output register.
// ----------------------------------------------------------------------------
module mono_framebuffer_line_drawer import mfld_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
  parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [COORD_W-1:0] in_x_first,
  input  logic [COORD_W-1:0] in_y_first,
  input  logic [COORD_W-1:0] in_x_last,
  input  logic [COORD_W-1:0] in_y_last,
  input  logic               in_color,
  input  logic [RADDR_W-1:0] in_read_addr,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_read_data,
  output logic               out_inverted_now
);

  job_t q_job, q_head;
  logic q_push, q_full, q_pop, q_empty;
  logic init_done;

  // intake: clamp, bounds checks, line setup
  mfld_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_x_first   (in_x_first),
    .in_y_first   (in_y_first),
    .in_x_last    (in_x_last),
    .in_y_last    (in_y_last),
    .in_color     (in_color),
    .in_read_addr (in_read_addr),
    .init_done    (init_done),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // decouples intake from execution
  mfld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // execution over the store, owns the result register
  mfld_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .init_done        (init_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_inverted_now (out_inverted_now)
  );

`ifndef NO_ASSERTIONS
  a_stall_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
      !init_done |-> in_stall)
    else $error("command taken before the store clear finished");
`endif

endmodule

// ===== test/framebuffer_shadow_checker.sv =====
// ----------------------------------------------------------------------------
// framebuffer_shadow_checker: scoreboard of the line drawer
// keeps a shadow copy of the pixel store and the invert flag, works out the
// result of every accepted command and compares it with the result channel
// ----------------------------------------------------------------------------
module framebuffer_shadow_checker import mfld_pkg::*; #(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [COORD_W-1:0] in_x_first,
  input  logic [COORD_W-1:0] in_y_first,
  input  logic [COORD_W-1:0] in_x_last,
  input  logic [COORD_W-1:0] in_y_last,
  input  logic               in_color,
  input  logic [RADDR_W-1:0] in_read_addr,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [BYTE_W-1:0]  out_read_data,
  input  logic               out_inverted_now,
  output int                 mismatches,
  output int                 pending
);

  localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGES;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              inverted_now;
  } frame_result_t;

  logic [BYTE_W-1:0] shadow_store [STORE_BYTES];
  logic              shadow_invert;
  frame_result_t     expected_results [$];

  // off-panel pixels are dropped, colour swapped while inverted
  function automatic void plot_pixel(input int x, input int y, input logic white);
    int idx;
    if (x >= PANEL_WIDTH || y >= PANEL_HEIGHT) return;
    idx = x + (y / 8) * PANEL_WIDTH;
    if (idx >= STORE_BYTES) return;
    if (shadow_invert) white = ~white;
    shadow_store[idx][y % 8] = white;
  endfunction

  function automatic void trace_line(input int ax, input int ay, input int bx,
                                     input int by, input logic white);
    int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, lo, hi;
    x0  = (ax >= PANEL_WIDTH)  ? PANEL_WIDTH - 1  : ax;
    y0  = (ay >= PANEL_HEIGHT) ? PANEL_HEIGHT - 1 : ay;
    x1  = (bx >= PANEL_WIDTH)  ? PANEL_WIDTH - 1  : bx;
    y1  = (by >= PANEL_HEIGHT) ? PANEL_HEIGHT - 1 : by;
    dx  = (x0 < x1) ? x1 - x0 : x0 - x1;
    dy  = (y0 < y1) ? y1 - y0 : y0 - y1;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    // straight lines and points cover the whole span
    if (dx == 0) begin
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      for (int i = lo; i <= hi; i++) plot_pixel(x0, i, white);
      return;
    end
    if (dy == 0) begin
      lo = (x0 < x1) ? x0 : x1;
      hi = (x0 < x1) ? x1 : x0;
      for (int i = lo; i <= hi; i++) plot_pixel(i, y0, white);
      return;
    end
    plot_pixel(x0, y0, white);
    while (!(x0 == x1 && y0 == y1)) begin
      e2 = err;
      if (e2 > -dx) begin
        err -= dy;
        x0  += sx;
      end
      if (e2 < dy) begin
        err += dx;
        y0  += sy;
      end
      plot_pixel(x0, y0, white);
    end
  endfunction

  function automatic frame_result_t execute_command(
      input logic [CMD_W-1:0]   cmd,
      input logic [COORD_W-1:0] xf, yf, xl, yl,
      input logic               color,
      input logic [RADDR_W-1:0] addr);
    frame_result_t r;
    r.read_data = BYTE_ZERO;
    case (cmd)
      CMD_PIXEL:  plot_pixel(int'(xf), int'(yf), color);
      CMD_LINE:   trace_line(int'(xf), int'(yf), int'(xl), int'(yl), color);
      CMD_FILL:   foreach (shadow_store[i]) shadow_store[i] = color ? BYTE_ONES : BYTE_ZERO;
      CMD_INVERT: begin
        shadow_invert = ~shadow_invert;
        foreach (shadow_store[i]) shadow_store[i] = ~shadow_store[i];
      end
      CMD_READ:   if (int'(addr) < STORE_BYTES) r.read_data = shadow_store[addr];
      default:    ;
    endcase
    r.inverted_now = shadow_invert;
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      foreach (shadow_store[i]) shadow_store[i] = BYTE_ZERO;
      shadow_invert = 1'b0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      // results first: one accepted at this edge cannot belong to this edge's command
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: read_data %0h inverted_now %0b",
                 out_read_data, out_inverted_now);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_read_data);
            mismatches = mismatches + 1;
          end
          if (out_inverted_now !== want.inverted_now) begin
            $error("inverted_now: expected %0b, got %0b", want.inverted_now,
                   out_inverted_now);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(execute_command(in_cmd, in_x_first, in_y_first,
                                                   in_x_last, in_y_last, in_color,
                                                   in_read_addr));
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/tb_mono_framebuffer_line_drawer.sv =====
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_line_drawer: testbench of the line drawer
// a directed sweep of commands and corner cases, then random command streams
// under four pacing phases; a shadow-store checker scores every result
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_line_drawer;
  import mfld_pkg::*;

  // no activity for this long means the block hung
  localparam int WATCHDOG_LIMIT = 20000;
  // quiet time after the last result to catch stray transactions
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_PER_PHASE = 75;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

  typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;
  typedef logic [CMD_W-1:0] cmd_code_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd = CMD_PIXEL;
  logic [COORD_W-1:0] in_x_first = '0;
  logic [COORD_W-1:0] in_y_first = '0;
  logic [COORD_W-1:0] in_x_last = '0;
  logic [COORD_W-1:0] in_y_last = '0;
  logic               in_color = 1'b0;
  logic [RADDR_W-1:0] in_read_addr = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  out_read_data;
  logic               out_inverted_now;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // last point touched, so that many reads land where drawing happened
  logic [COORD_W-1:0] recent_x = '0;
  logic [COORD_W-1:0] recent_y = '0;

  mono_framebuffer_line_drawer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_first       (in_x_first),
    .in_y_first       (in_y_first),
    .in_x_last        (in_x_last),
    .in_y_last        (in_y_last),
    .in_color         (in_color),
    .in_read_addr     (in_read_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_inverted_now (out_inverted_now)
  );

  framebuffer_shadow_checker scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_x_first       (in_x_first),
    .in_y_first       (in_y_first),
    .in_x_last        (in_x_last),
    .in_y_last        (in_y_last),
    .in_color         (in_color),
    .in_read_addr     (in_read_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_inverted_now (out_inverted_now),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure, independent of anything the block does
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog: counts cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("mono_framebuffer_line_drawer: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic set_pace(input pace_t pace);
    case (pace)
      PACE_FULL: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
      end
      PACE_SENDER_IDLE: begin
        send_idle_pct  <= 86;
        recv_stall_pct <= 0;
      end
      PACE_RECEIVER_STALL: begin
        send_idle_pct  <= 0;
        recv_stall_pct <= 86;
      end
      default: begin
        send_idle_pct  <= 22;
        recv_stall_pct <= 22;
      end
    endcase
  endtask

  // one command transaction: optional idle gap, then hold until accepted;
  // valid stays high when the next command follows with no gap
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] xf,
                       input logic [COORD_W-1:0] yf, input logic [COORD_W-1:0] xl,
                       input logic [COORD_W-1:0] yl, input logic color,
                       input logic [RADDR_W-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_x_first   <= xf;
    in_y_first   <= yf;
    in_x_last    <= xl;
    in_y_last    <= yl;
    in_color     <= color;
    in_read_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // store byte holding pixel (x, y)
  function automatic logic [RADDR_W-1:0] byte_of(input int x, input int y);
    return RADDR_W'(x + (y / 8) * DEF_PANEL_WIDTH);
  endfunction

  // mostly on the panel, sometimes anywhere in the 8-bit range
  function automatic logic [COORD_W-1:0] pick_coord(input int extent);
    if ($urandom_range(9) == 0) return COORD_W'($urandom_range(255));
    return COORD_W'($urandom_range(extent - 1));
  endfunction

  // end point near the start keeps most lines short
  function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c, input int extent);
    int v;
    if ($urandom_range(3) == 0) return pick_coord(extent);
    v = int'(c) + $urandom_range(24) - 12;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return COORD_W'(v);
  endfunction

  task automatic issue_random();
    int roll;
    logic [COORD_W-1:0] xf, yf, xl, yl;
    logic [RADDR_W-1:0] addr;
    roll = $urandom_range(99);
    xf   = pick_coord(DEF_PANEL_WIDTH);
    yf   = pick_coord(DEF_PANEL_HEIGHT);
    xl   = near(xf, DEF_PANEL_WIDTH);
    yl   = near(yf, DEF_PANEL_HEIGHT);
    addr = RADDR_W'($urandom_range(1023));
    if (roll < 22) begin
      issue(CMD_PIXEL, xf, yf, xl, yl, 1'($urandom), addr);
      recent_x = xf;
      recent_y = yf;
    end else if (roll < 52) begin
      issue(CMD_LINE, xf, yf, xl, yl, 1'($urandom), addr);
      recent_x = xl;
      recent_y = yl;
    end else if (roll < 88) begin
      // half of the reads go near the last drawn point
      if ($urandom_range(1) == 0 && recent_x < DEF_PANEL_WIDTH && recent_y < DEF_PANEL_HEIGHT)
        addr = byte_of(int'(recent_x) + ((recent_x > 0) ? -int'($urandom_range(1)) : 0),
                       int'(recent_y));
      issue(CMD_READ, xf, yf, xl, yl, 1'($urandom), addr);
    end else if (roll < 91) begin
      issue(CMD_FILL, xf, yf, xl, yl, 1'($urandom), addr);
    end else if (roll < 95) begin
      issue(CMD_INVERT, xf, yf, xl, yl, 1'($urandom), addr);
    end else begin
      issue(cmd_code_t'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)), xf, yf, xl, yl,
            1'($urandom), addr);
    end
  endtask

  initial begin
    set_pace(PACE_FULL);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a cleared store, panel corners and pixels off the panel
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, 0);
    issue(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 0);
    issue(CMD_PIXEL, 127, 63, 0, 0, 1'b1, 0);
    issue(CMD_PIXEL, 128, 0, 0, 0, 1'b1, 0);
    issue(CMD_PIXEL, 0, 64, 0, 0, 1'b1, 0);
    issue(CMD_PIXEL, 255, 255, 0, 0, 1'b1, 0);
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, byte_of(127, 63));
    issue(CMD_PIXEL, 0, 0, 0, 0, 1'b0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, 0);
    // horizontal, vertical, single point, steep, shallow and reversed lines
    issue(CMD_LINE,  0, 5, 127, 5, 1'b1, 0);
    issue(CMD_LINE,  10, 0, 10, 63, 1'b1, 0);
    issue(CMD_LINE,  3, 3, 3, 3, 1'b1, 0);
    issue(CMD_LINE,  0, 0, 5, 63, 1'b1, 0);
    issue(CMD_LINE,  127, 0, 0, 20, 1'b1, 0);
    // end points clamped to the panel edge, then a black diagonal
    issue(CMD_LINE,  200, 200, 255, 0, 1'b1, 0);
    issue(CMD_LINE,  40, 40, 20, 20, 1'b0, 0);
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, byte_of(10, 5));
    // drawing while inverted swaps the colour
    issue(CMD_INVERT, 0, 0, 0, 0, 1'b0, 0);
    issue(CMD_PIXEL, 50, 30, 0, 0, 1'b1, 0);
    issue(CMD_LINE,  60, 10, 70, 50, 1'b1, 0);
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, byte_of(50, 30));
    issue(CMD_INVERT, 0, 0, 0, 0, 1'b0, 0);
    // fill ignores the invert flag; spare codes only report
    issue(CMD_FILL,  0, 0, 0, 0, 1'b1, 0);
    issue(CMD_READ,  0, 0, 0, 0, 1'b0, 1023);
    issue(CMD_FILL,  0, 0, 0, 0, 1'b0, 0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      issue(cmd_code_t'(c), 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 10'h3FF);

    // random streams, every pacing phase visited twice
    for (int round = 0; round < 2; round++) begin
      for (int p = PACE_FULL; p <= PACE_BOTH; p++) begin
        set_pace(pace_t'(p));
        repeat (RANDOM_PER_PHASE) issue_random();
      end
    end
    in_valid <= 1'b0;

    // drain: let the checker book the last command, wait out every expected
    // result, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("mono_framebuffer_line_drawer: match");
    end else begin
      $display("mono_framebuffer_line_drawer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mfld_pkg.sv
rtl/core/mfld_ram.sv
rtl/core/mfld_queue.sv
rtl/core/mfld_front.sv
rtl/core/mfld_back.sv
rtl/core/mono_framebuffer_line_drawer.sv
test/framebuffer_shadow_checker.sv
test/tb_mono_framebuffer_line_drawer.sv
